// ----- design/ftrk_pkg.sv -----
// Shared types and constants for the TCP flow tracker: chain token, phases, config.
package ftrk_pkg;

  // Number of flow entries, one per cell in the chain
  localparam int FLOW_ENTRIES = 64;

  localparam int KEY_W  = 64;
  localparam int TIME_W = 64;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PENDING_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_GRACE     = 1'b1;

  localparam logic [TIME_W-1:0] PENDING_TIMEOUT_RST = 64'd5000000000;
  localparam logic [TIME_W-1:0] CLOSE_GRACE_RST     = 64'd10000000000;

  // Flow phase held by each entry
  typedef enum logic [1:0] {
    PH_PENDING     = 2'd0,
    PH_ESTABLISHED = 2'd1,
    PH_CLOSING     = 2'd2
  } phase_t;

  // Kind of pass a token makes down the chain
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_ALLOC  = 1'b1
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_ALLOC  = 2'd2
  } state_t;

  // Window settings broadcast to every cell
  typedef struct packed {
    logic [TIME_W-1:0] pending_timeout;
    logic [TIME_W-1:0] close_grace;
  } cfg_t;

  // Token handed from cell to cell, one hop per cycle
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic              egress;
    logic              syn;
    logic              ack;
    logic              fin;
    logic              rst;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic              hit;        // some cell held the key
    logic              ok;         // hit cell found the flow within its window
    logic              free_seen;  // some cell was free
    logic              claimed;    // allocation pass: a free cell took the flow
  } tok_t;

endpackage

// ----- design/ftrk_cell.sv -----
// One flow-table cell: holds a single entry and acts on the token passing through.
module ftrk_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ftrk_pkg::cfg_t  cfg_i,
  input  ftrk_pkg::tok_t  tok_i,
  output ftrk_pkg::tok_t  tok_o
);

  logic                         valid_r, valid_nxt;
  logic [ftrk_pkg::KEY_W-1:0]   key_r, key_nxt;
  ftrk_pkg::phase_t             phase_r, phase_nxt;
  logic [ftrk_pkg::TIME_W-1:0]  time_r, time_nxt;
  ftrk_pkg::tok_t               tok_r, tok_nxt;
  logic                         tok_vld_r;

  logic                         match;
  logic                         take;
  logic [ftrk_pkg::TIME_W-1:0]  age;
  logic                         win_ok;

  // Key compare and window check against this entry
  assign match = tok_i.vld && (tok_i.op == ftrk_pkg::OP_LOOKUP) && valid_r &&
                 (key_r == tok_i.key);
  assign take  = tok_i.vld && (tok_i.op == ftrk_pkg::OP_ALLOC) && !tok_i.claimed &&
                 !valid_r;
  assign age   = tok_i.now - time_r;
  assign win_ok = (phase_r == ftrk_pkg::PH_ESTABLISHED) ||
                  ((phase_r == ftrk_pkg::PH_PENDING) && (age < cfg_i.pending_timeout)) ||
                  ((phase_r == ftrk_pkg::PH_CLOSING) && (age < cfg_i.close_grace));

  // Entry update and outgoing token
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    phase_nxt = phase_r;
    time_nxt  = time_r;
    tok_nxt   = tok_i;

    if (tok_i.vld && (tok_i.op == ftrk_pkg::OP_LOOKUP) && !valid_r) begin
      tok_nxt.free_seen = 1'b1;
    end

    if (match) begin
      tok_nxt.hit = 1'b1;
      if (tok_i.rst) begin
        valid_nxt = 1'b0;
      end else if (tok_i.fin) begin
        phase_nxt = ftrk_pkg::PH_CLOSING;
        time_nxt  = tok_i.now;
      end else if (tok_i.egress) begin
        if (tok_i.syn) begin
          phase_nxt = ftrk_pkg::PH_PENDING;
          time_nxt  = tok_i.now;
        end
      end else if (!(tok_i.syn && !tok_i.ack)) begin
        // ingress data or handshake: admit within window, promote pending
        tok_nxt.ok = win_ok;
        if (win_ok && (phase_r == ftrk_pkg::PH_PENDING)) begin
          phase_nxt = ftrk_pkg::PH_ESTABLISHED;
          time_nxt  = tok_i.now;
        end
      end
    end

    if (take) begin
      valid_nxt       = 1'b1;
      key_nxt         = tok_i.key;
      phase_nxt       = ftrk_pkg::PH_PENDING;
      time_nxt        = tok_i.now;
      tok_nxt.claimed = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_vld_r <= tok_nxt.vld;
    end
  end

  // Entry and token payload
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    phase_r <= phase_nxt;
    time_r  <= time_nxt;
    tok_r   <= tok_nxt;
  end

  // Outgoing token: payload with the reset-cleared valid mark
  always_comb begin
    tok_o     = tok_r;
    tok_o.vld = tok_vld_r;
  end

endmodule

// ----- design/tcp_handshake_flow_tracker_core.sv -----
// Top level of the TCP flow tracker: sequencer, config registers and the cell chain.
// Each segment makes one pass down the chain from the accepting edge to out_strobe, or two
// passes for an egress SYN that allocates a new entry (a lookup pass, then an allocation pass).
// A new segment is taken only once the previous result is out, since busy stays high until then;
// busy drops the cycle the result is registered.
// Each word makes one hop per cell per cycle, so the chain length sets the time to a result.
// Synchronous active-low reset clears all entry valid bits, the sequencer and config.
// The receiver cannot stall: out_strobe lasts one cycle per result.
module tcp_handshake_flow_tracker_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_peer_ip,
  input  logic [15:0] in_peer_port,
  input  logic [15:0] in_local_port,
  input  logic        in_flag_syn,
  input  logic        in_flag_ack,
  input  logic        in_flag_fin,
  input  logic        in_flag_rst,
  input  logic [63:0] in_now_ns,
  output logic        out_strobe,
  output logic        out_verdict,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ftrk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_wdata
);

  ftrk_pkg::state_t state_r, state_nxt;
  ftrk_pkg::cfg_t   cfg_r;
  ftrk_pkg::tok_t   chain [ftrk_pkg::FLOW_ENTRIES+1];
  ftrk_pkg::tok_t   inj_tok;
  ftrk_pkg::tok_t   tail;

  logic out_strobe_r, out_strobe_nxt;
  logic out_verdict_r, out_verdict_nxt;
  logic out_full_r, out_full_nxt;
  logic accept;
  logic syn_new;
  logic need_alloc;

  assign busy      = (state_r != ftrk_pkg::ST_IDLE);
  assign accept    = start && !busy;
  // windows change only between segments
  assign cfg_ready = !busy && !start;
  assign tail      = chain[ftrk_pkg::FLOW_ENTRIES];

  // Egress SYN with no existing flow: needs a free entry
  assign syn_new    = tail.egress && !tail.rst && !tail.fin && tail.syn && !tail.hit;
  assign need_alloc = syn_new && tail.free_seen;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pending_timeout <= ftrk_pkg::PENDING_TIMEOUT_RST;
      cfg_r.close_grace     <= ftrk_pkg::CLOSE_GRACE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ftrk_pkg::CFG_PENDING_TIMEOUT: cfg_r.pending_timeout <= cfg_wdata;
        ftrk_pkg::CFG_CLOSE_GRACE:     cfg_r.close_grace     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ftrk_pkg::ST_IDLE: begin
        if (start) state_nxt = ftrk_pkg::ST_LOOKUP;
      end
      ftrk_pkg::ST_LOOKUP: begin
        if (tail.vld) state_nxt = need_alloc ? ftrk_pkg::ST_ALLOC : ftrk_pkg::ST_IDLE;
      end
      ftrk_pkg::ST_ALLOC: begin
        if (tail.vld) state_nxt = ftrk_pkg::ST_IDLE;
      end
      default: state_nxt = ftrk_pkg::ST_IDLE;
    endcase
  end

  // Outputs: token injection and result word
  always_comb begin
    inj_tok         = '0;
    out_strobe_nxt  = 1'b0;
    out_verdict_nxt = 1'b0;
    out_full_nxt    = 1'b0;
    unique case (state_r)
      ftrk_pkg::ST_IDLE: begin
        if (accept) begin
          inj_tok.vld    = 1'b1;
          inj_tok.op     = ftrk_pkg::OP_LOOKUP;
          inj_tok.egress = in_func;
          inj_tok.syn    = in_flag_syn;
          inj_tok.ack    = in_flag_ack;
          inj_tok.fin    = in_flag_fin;
          inj_tok.rst    = in_flag_rst;
          inj_tok.key    = {in_peer_ip, in_peer_port, in_local_port};
          inj_tok.now    = in_now_ns;
        end
      end
      ftrk_pkg::ST_LOOKUP: begin
        if (tail.vld) begin
          if (need_alloc) begin
            // second pass: lowest free cell claims the flow
            inj_tok     = tail;
            inj_tok.op  = ftrk_pkg::OP_ALLOC;
            inj_tok.claimed = 1'b0;
          end else begin
            out_strobe_nxt = 1'b1;
            out_full_nxt   = syn_new;
            if (!tail.egress) begin
              if (tail.rst || tail.fin) begin
                out_verdict_nxt = !tail.hit;
              end else if (tail.syn && !tail.ack) begin
                out_verdict_nxt = 1'b0;
              end else begin
                out_verdict_nxt = !tail.ok;
              end
            end
          end
        end
      end
      ftrk_pkg::ST_ALLOC: begin
        if (tail.vld) out_strobe_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ftrk_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r <= out_verdict_nxt;
    out_full_r    <= out_full_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_verdict    = out_verdict_r;
  assign out_table_full = out_full_r;

  // Cell chain
  assign chain[0] = inj_tok;

  for (genvar g = 0; g < ftrk_pkg::FLOW_ENTRIES; g++) begin : g_cell
    ftrk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg_i (cfg_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  // Checks
  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r != ftrk_pkg::ST_IDLE))
    else $error("result word without a segment in flight");

  a_full_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_table_full) |-> !out_verdict)
    else $error("table full reported with a drop");

  a_tail_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r != ftrk_pkg::ST_IDLE))
    else $error("token left the chain while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted segment did not raise busy");

endmodule

// ----- dv/flow_tracker_checker.sv -----
// Flow tracker checker: mirrors the flow table, predicts each verdict and compares results.
module flow_tracker_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           in_func,
  input  logic [31:0]                    in_peer_ip,
  input  logic [15:0]                    in_peer_port,
  input  logic [15:0]                    in_local_port,
  input  logic                           in_flag_syn,
  input  logic                           in_flag_ack,
  input  logic                           in_flag_fin,
  input  logic                           in_flag_rst,
  input  logic [63:0]                    in_now_ns,
  input  logic                           out_strobe,
  input  logic                           out_verdict,
  input  logic                           out_table_full,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ftrk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_wdata,
  output int                             fail_count,
  output int                             pending_count
);

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  typedef struct packed {
    logic verdict;
    logic table_full;
  } outcome_t;

  // Verdicts owed by the block, oldest first
  outcome_t outcome_q[$];

  // Shadow flow table and window settings
  logic                        flow_vld  [ftrk_pkg::FLOW_ENTRIES];
  logic [ftrk_pkg::KEY_W-1:0]  flow_key  [ftrk_pkg::FLOW_ENTRIES];
  ftrk_pkg::phase_t            flow_ph   [ftrk_pkg::FLOW_ENTRIES];
  logic [ftrk_pkg::TIME_W-1:0] flow_time [ftrk_pkg::FLOW_ENTRIES];
  logic [ftrk_pkg::TIME_W-1:0] pend_window;
  logic [ftrk_pkg::TIME_W-1:0] grace_window;

  // Apply one segment to the shadow table and work out its verdict
  task automatic judge_segment(input logic egress, input logic [ftrk_pkg::KEY_W-1:0] key,
                               input logic syn, input logic ack, input logic fin,
                               input logic rst, input logic [ftrk_pkg::TIME_W-1:0] now,
                               output outcome_t res);
    int hit;
    int slot;
    logic ok;
    logic [ftrk_pkg::TIME_W-1:0] age;
    hit  = -1;
    slot = -1;
    res  = '{verdict: VERDICT_PASS, table_full: 1'b0};
    for (int i = 0; i < ftrk_pkg::FLOW_ENTRIES; i++) begin
      if (hit < 0 && flow_vld[i] && flow_key[i] == key) hit = i;
      if (slot < 0 && !flow_vld[i]) slot = i;
    end
    if (egress) begin
      // egress records state only; RST beats FIN beats SYN
      if (rst) begin
        if (hit >= 0) flow_vld[hit] = 1'b0;
      end else if (fin) begin
        if (hit >= 0) begin
          flow_ph[hit]   = ftrk_pkg::PH_CLOSING;
          flow_time[hit] = now;
        end
      end else if (syn) begin
        if (hit >= 0) slot = hit;
        if (slot >= 0) begin
          flow_vld[slot]  = 1'b1;
          flow_key[slot]  = key;
          flow_ph[slot]   = ftrk_pkg::PH_PENDING;
          flow_time[slot] = now;
        end else begin
          res.table_full = 1'b1;
        end
      end
    end else begin
      if (rst) begin
        if (hit < 0) res.verdict = VERDICT_DROP;
        else flow_vld[hit] = 1'b0;
      end else if (fin) begin
        if (hit < 0) begin
          res.verdict = VERDICT_DROP;
        end else begin
          flow_ph[hit]   = ftrk_pkg::PH_CLOSING;
          flow_time[hit] = now;
        end
      end else if (!(syn && !ack)) begin
        // bare SYN falls through untouched; the rest needs a live flow
        ok = 1'b0;
        if (hit >= 0) begin
          age = now - flow_time[hit];
          ok  = flow_ph[hit] == ftrk_pkg::PH_ESTABLISHED ||
                (flow_ph[hit] == ftrk_pkg::PH_PENDING && age < pend_window) ||
                (flow_ph[hit] == ftrk_pkg::PH_CLOSING && age < grace_window);
        end
        if (!ok) begin
          res.verdict = VERDICT_DROP;
        end else if (flow_ph[hit] == ftrk_pkg::PH_PENDING) begin
          flow_ph[hit]   = ftrk_pkg::PH_ESTABLISHED;
          flow_time[hit] = now;
        end
      end
    end
  endtask

  // Watch the three channels at each rising edge
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < ftrk_pkg::FLOW_ENTRIES; i++) flow_vld[i] = 1'b0;
      pend_window  = ftrk_pkg::PENDING_TIMEOUT_RST;
      grace_window = ftrk_pkg::CLOSE_GRACE_RST;
      outcome_q.delete();
      fail_count <= 0;
    end else begin
      // result word first: it belongs to an earlier segment
      if (out_strobe) begin
        got = '{verdict: out_verdict, table_full: out_table_full};
        if (outcome_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result word, verdict %0b table_full %0b",
                   $time, got.verdict, got.table_full);
        end else begin
          want = outcome_q.pop_front();
          if (got.verdict != want.verdict) begin
            errs++;
            $display("%0t: verdict expected %0b actual %0b",
                     $time, want.verdict, got.verdict);
          end
          if (got.table_full != want.table_full) begin
            errs++;
            $display("%0t: table_full expected %0b actual %0b",
                     $time, want.table_full, got.table_full);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ftrk_pkg::CFG_PENDING_TIMEOUT: pend_window  = cfg_wdata;
          ftrk_pkg::CFG_CLOSE_GRACE:     grace_window = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        judge_segment(in_func, {in_peer_ip, in_peer_port, in_local_port},
                      in_flag_syn, in_flag_ack, in_flag_fin, in_flag_rst, in_now_ns, want);
        outcome_q.push_back(want);
      end
      fail_count <= fail_count + errs;
    end
    pending_count <= outcome_q.size();
  end

endmodule

// ----- dv/tb_tcp_handshake_flow_tracker_core.sv -----
// Testbench top for the TCP flow tracker: clock, reset, segment stimulus and verdict.
module tb_tcp_handshake_flow_tracker_core;

  localparam logic DIR_INGRESS = 1'b0;
  localparam logic DIR_EGRESS  = 1'b1;

  // TCP flags as {syn, ack, fin, rst}
  localparam logic [3:0] F_NONE = 4'b0000;
  localparam logic [3:0] F_SYN  = 4'b1000;
  localparam logic [3:0] F_ACK  = 4'b0100;
  localparam logic [3:0] F_FIN  = 4'b0010;
  localparam logic [3:0] F_RST  = 4'b0001;

  // Flow life stages used only to shape the stimulus
  localparam int STG_IDLE    = 0;
  localparam int STG_SYNSENT = 1;
  localparam int STG_OPEN    = 2;
  localparam int STG_CLOSING = 3;

  localparam logic [63:0] KEY_LOW  = 64'h0;
  localparam logic [63:0] KEY_HIGH = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_MID  = 64'hC0A8_0001_01BB_D431;

  localparam int POOL_SIZE    = 80;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 2 * ftrk_pkg::FLOW_ENTRIES + 8;
  localparam int CYCLE_LIMIT  = 2_500_000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic                           in_func;
  logic [31:0]                    in_peer_ip;
  logic [15:0]                    in_peer_port;
  logic [15:0]                    in_local_port;
  logic                           in_flag_syn;
  logic                           in_flag_ack;
  logic                           in_flag_fin;
  logic                           in_flag_rst;
  logic [63:0]                    in_now_ns;
  logic                           out_strobe;
  logic                           out_verdict;
  logic                           out_table_full;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [ftrk_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                    cfg_wdata;
  int                             fail_count;
  int                             pending_count;
  int                             cycle_count = 0;
  int                             calm_left = 0;

  logic [63:0] flow_pool  [POOL_SIZE];
  int          flow_stage [POOL_SIZE];

  tcp_handshake_flow_tracker_core u_top (.*);

  flow_tracker_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender idling: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 60);
    return $urandom_range(61, 200);
  endfunction

  // Offer one segment word and hold it until the block takes it
  task automatic send_segment(input int gap, input logic dir, input logic [63:0] key,
                              input logic [3:0] flags, input logic [63:0] now);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = dir;
    {in_peer_ip, in_peer_port, in_local_port} = key;
    {in_flag_syn, in_flag_ack, in_flag_fin, in_flag_rst} = flags;
    in_now_ns = now;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ftrk_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering and wait until every verdict is back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
  endtask

  initial begin
    logic [63:0] pend;
    logic [63:0] grace;
    logic [63:0] step_max;
    logic [63:0] step;
    logic [63:0] clock_ns;
    logic [63:0] key;
    logic [63:0] now;
    logic [3:0]  flags;
    logic        dir;
    int          idx;
    int          r;

    start         = 1'b0;
    in_func       = DIR_INGRESS;
    in_peer_ip    = '0;
    in_peer_port  = '0;
    in_local_port = '0;
    in_flag_syn   = 1'b0;
    in_flag_ack   = 1'b0;
    in_flag_fin   = 1'b0;
    in_flag_rst   = 1'b0;
    in_now_ns     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = ftrk_pkg::CFG_PENDING_TIMEOUT;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every branch at the reset windows, extremes of keys and time
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_ACK, 64'd0);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_RST, 64'd0);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_FIN, 64'd0);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_SYN, 64'd0);
    send_segment(pick_gap(), DIR_EGRESS, KEY_LOW, F_NONE, 64'd0);
    send_segment(pick_gap(), DIR_EGRESS, KEY_LOW, F_FIN, 64'd0);
    send_segment(pick_gap(), DIR_EGRESS, KEY_LOW, F_RST, 64'd0);
    send_segment(pick_gap(), DIR_EGRESS, KEY_LOW, F_SYN | F_ACK, 64'd0);
    // pending one tick inside its window, then established
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_SYN | F_ACK, 64'd4_999_999_999);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_ACK, KEY_HIGH);
    send_segment(pick_gap(), DIR_EGRESS, KEY_LOW, F_FIN, 64'd1000);
    // closing: last tick of the grace window, then exactly on its edge
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_ACK, 64'd10_000_000_999);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_ACK, 64'd10_000_001_000);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_RST, 64'd10_000_001_000);
    send_segment(pick_gap(), DIR_INGRESS, KEY_LOW, F_ACK, 64'd10_000_001_000);
    // pending across the time wrap
    send_segment(pick_gap(), DIR_EGRESS, KEY_HIGH, F_SYN, 64'hFFFF_FFFF_FFFF_FF00);
    send_segment(pick_gap(), DIR_INGRESS, KEY_HIGH, F_ACK, 64'd4_999_999_743);
    // pending exactly at its timeout, then refreshed by a repeat SYN
    send_segment(pick_gap(), DIR_EGRESS, KEY_MID, F_SYN, 64'd0);
    send_segment(pick_gap(), DIR_INGRESS, KEY_MID, F_ACK, 64'd5_000_000_000);
    send_segment(pick_gap(), DIR_EGRESS, KEY_MID, F_SYN, 64'd10);
    send_segment(pick_gap(), DIR_INGRESS, KEY_MID, F_FIN | F_ACK, 64'd20);
    send_segment(pick_gap(), DIR_INGRESS, KEY_MID, F_ACK, 64'd20);
    send_segment(pick_gap(), DIR_EGRESS, KEY_MID, F_RST, 64'd30);
    // all flags at once: RST wins
    send_segment(pick_gap(), DIR_EGRESS, KEY_HIGH, F_SYN | F_ACK | F_FIN | F_RST, KEY_HIGH);
    send_segment(pick_gap(), DIR_INGRESS, KEY_HIGH, F_FIN | F_ACK, KEY_HIGH);

    // Flow pool: more flows than entries so the table fills up
    flow_pool[0] = KEY_LOW;
    flow_pool[1] = KEY_HIGH;
    for (int i = 2; i < POOL_SIZE; i++) flow_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) flow_stage[i] = STG_IDLE;
    clock_ns = 64'd20_000_000_000;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          pend = ftrk_pkg::PENDING_TIMEOUT_RST; grace = ftrk_pkg::CLOSE_GRACE_RST;
          step_max = 64'd150_000_000;
        end
        1: begin
          pend = '0; grace = '0; step_max = 64'd50;
        end
        2: begin
          pend = '1; grace = '1; step_max = '1;
        end
        3: begin
          pend = 64'd1000; grace = 64'd400; step_max = 64'd25;
        end
        4: begin
          pend = 64'd1; grace = 64'd2; step_max = 64'd1;
        end
        5: begin
          pend     = {$urandom, $urandom} >> $urandom_range(20, 50);
          grace    = {$urandom, $urandom} >> $urandom_range(20, 50);
          step_max = pend >> 5;
          clock_ns = '1 - (pend >> 1);
        end
        default: begin
          pend = 64'd600; grace = '1; step_max = 64'd15; clock_ns = '1 - 64'd20000;
        end
      endcase
      write_reg(ftrk_pkg::CFG_PENDING_TIMEOUT, pend);
      write_reg(ftrk_pkg::CFG_CLOSE_GRACE, grace);

      repeat (PHASE_ITEMS) begin
        idx = $urandom_range(0, POOL_SIZE - 1);
        key = flow_pool[idx];
        if ($urandom_range(0, 99) < 15) begin
          // noise: any direction, any flags, sometimes a stranger
          dir   = 1'($urandom_range(0, 1));
          flags = 4'($urandom_range(0, 15));
          if ($urandom_range(0, 2) == 0) key = {$urandom, $urandom};
        end else begin
          case (flow_stage[idx])
            STG_IDLE: begin
              dir   = DIR_EGRESS;
              flags = F_SYN | ($urandom_range(0, 3) == 0 ? F_ACK : F_NONE);
              flow_stage[idx] = STG_SYNSENT;
            end
            STG_SYNSENT: begin
              dir = DIR_INGRESS;
              if ($urandom_range(0, 4) == 0) begin
                flags = F_SYN;
              end else begin
                flags = F_SYN | F_ACK;
                flow_stage[idx] = STG_OPEN;
              end
            end
            STG_OPEN: begin
              r   = $urandom_range(0, 99);
              dir = 1'($urandom_range(0, 1));
              if (r < 12) begin
                flags = F_FIN | ($urandom_range(0, 1) ? F_ACK : F_NONE);
                flow_stage[idx] = STG_CLOSING;
              end else if (r < 16) begin
                flags = F_RST | ($urandom_range(0, 1) ? F_ACK : F_NONE);
                flow_stage[idx] = STG_IDLE;
              end else begin
                flags = F_ACK;
              end
            end
            default: begin
              r = $urandom_range(0, 99);
              if (r < 25) begin
                dir   = 1'($urandom_range(0, 1));
                flags = F_RST;
                flow_stage[idx] = STG_IDLE;
              end else if (r < 35) begin
                dir   = DIR_EGRESS;
                flags = F_SYN;
                flow_stage[idx] = STG_SYNSENT;
              end else begin
                dir   = DIR_INGRESS;
                flags = F_ACK | ($urandom_range(0, 1) ? F_FIN : F_NONE);
              end
            end
          endcase
        end
        // time mostly moves forward, now and then it jumps anywhere
        if ($urandom_range(0, 24) == 0) begin
          now = {$urandom, $urandom};
        end else begin
          step = {$urandom, $urandom};
          if (step_max != '1) step = step % (step_max + 64'd1);
          clock_ns = clock_ns + step;
          now = clock_ns;
        end
        send_segment(pick_gap(), dir, key, flags, now);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
